FILE: src/pitac_pkg.sv
package pitac_pkg;

  localparam int MEDIAN_DEPTH = 3;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_MED  = 14'b00000000000010,
    S_ERR  = 14'b00000000000100,
    S_ZMUL = 14'b00000000001000,
    S_ZUPD = 14'b00000000010000,
    S_QMUL = 14'b00000000100000,
    S_SQRT = 14'b00000001000000,
    S_TMUL = 14'b00000010000000,
    S_TSAT = 14'b00000100000000,
    S_FMUL = 14'b00001000000000,
    S_FUPD = 14'b00010000000000,
    S_CMUL = 14'b00100000000000,
    S_CSAT = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MEDIAN_EN = 2'd0;
  localparam logic [1:0] REG_LPF_GAIN  = 2'd1;
  localparam logic [1:0] REG_SCALE     = 2'd2;

  localparam logic        MEDIAN_EN_RST = 1'b1;
  localparam logic [15:0] LPF_GAIN_RST  = 16'd39322;
  localparam logic [15:0] SCALE_RST     = 16'd256;

  localparam logic signed [17:0] ZERO_GAIN_Q16    = 18'sd9830;
  localparam logic signed [17:0] TWO_OVER_RHO_Q16 = 18'sd106999;
  localparam logic signed [17:0] CMS_PER_MS       = 18'sd100;
  localparam int                 CAL_TOL_Q16      = 66405;
  localparam logic [31:0]        CAL_HOLD_MS      = 32'd250;
  localparam logic [63:0]        SPEED_MAX        = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [23:0]        CMS_MAX          = 24'hFF_FFFF;

endpackage

FILE: src/pitot_airspeed_conditioner_top.sv
// Channel  Dir  Handshake          Payload
// in_      in   tvalid/tready      tdata {now_ms, pressure_pa}, tuser func
// out_     out  tvalid/tready      tdata {filtered_pressure_pa, airspeed_cms}, tuser calibrated
// cfg_     in   APB psel/penable   3 registers at byte 0, 4, 8; pready tied high
//
// Calibrated sample: SW = (PRESSURE_BITS+31)/2 (26 at 21 bits) result bits come from the square root
//   loop of the shared unit, one result bit a cycle.
// Calibrating sample: median, error, offset multiply and offset update steps. Restart item: output step only.
// in_tready is high only while idle; one result waits in the output register,
//   and a finished item holds in its last step while that register is still full.
// Synchronous active-low reset; config registers and filter state take reset values.
module pitot_airspeed_conditioner_top
  import pitac_pkg::*;
#(
  parameter int PRESSURE_BITS = 21
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // [PB-1:0] pressure_pa, [PB+31:PB] now_ms, zero pad
  input  logic [((PRESSURE_BITS+39)/8)*8-1:0]          in_tdata,
  // [0] func
  input  logic                                         in_tuser,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // [23:0] airspeed_cms, [PB+23:24] filtered_pressure_pa, zero pad
  output logic [((PRESSURE_BITS+31)/8)*8-1:0]          out_tdata,
  // [0] calibrated
  output logic                                         out_tuser,
  input  logic                                         cfg_psel,
  input  logic                                         cfg_penable,
  input  logic                                         cfg_pwrite,
  input  logic [3:0]                                   cfg_paddr,
  input  logic [31:0]                                  cfg_pwdata,
  output logic [31:0]                                  cfg_prdata,
  output logic                                         cfg_pready
);

  localparam int PB  = PRESSURE_BITS;
  localparam int ODW = ((PB + 31) / 8) * 8;
  localparam int ZW  = PB + 16;
  localparam int EW  = PB + 17;
  localparam int QW  = PB + 30;
  localparam int SW  = (QW + 1) / 2;
  localparam int CW  = $clog2(SW);
  localparam int AW  = (PB + 18 > 42) ? PB + 18 : 42;
  localparam int TW  = SW + 10;

  function automatic logic signed [PB-1:0] med3(input logic signed [PB-1:0] a,
                                                input logic signed [PB-1:0] b,
                                                input logic signed [PB-1:0] c);
    logic signed [PB-1:0] lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  state_t state_r, state_nxt;

  logic                        men_r;
  logic [15:0]                 gain_r;
  logic [15:0]                 scale_r;

  logic signed [PB-1:0]        ring_r [MEDIAN_DEPTH];
  logic [1:0]                  idx_r;
  logic                        full_r;
  logic signed [ZW-1:0]        zero_r;
  logic [31:0]                 hold_r;
  logic                        cal_r;
  logic [39:0]                 smooth_r;

  logic signed [PB-1:0]        p_r;
  logic [31:0]                 now_r;
  logic signed [EW-1:0]        e_r;
  logic signed [AW+17:0]       prod_r;
  logic [QW-1:0]               rem_r;
  logic [QW:0]                 res_r;
  logic [CW-1:0]               cnt_r;
  logic signed [40:0]          diff_r;
  logic [23:0]                 cms_r;

  logic                        out_valid_r;
  logic [23:0]                 out_cms_r;
  logic signed [PB-1:0]        out_filt_r;
  logic                        out_cal_r;

  logic signed [PB-1:0]        pin;
  logic [31:0]                 nin;
  logic [1:0]                  widx;
  logic signed [EW-1:0]        e_nxt;
  logic [EW-1:0]               d_abs;
  logic signed [AW-1:0]        mul_a;
  logic signed [17:0]          mul_b;
  logic signed [AW+17:0]       mul_p;
  logic [QW:0]                 sq_bit;
  logic [QW:0]                 sq_trial;
  logic                        sq_take;
  logic [TW-1:0]               t_raw;
  logic [63:0]                 t_ext;
  logic [39:0]                 t_sat;
  logic signed [EW-1:0]        zsum;
  logic [31:0]                 elapsed;
  logic                        err_small;
  logic [40:0]                 ssum;
  logic [30:0]                 c_raw;
  logic                        cfg_wr;

  assign pin       = in_tdata[PB-1:0];
  assign nin       = in_tdata[PB+31:PB];
  assign widx      = (idx_r < 2'(MEDIAN_DEPTH)) ? idx_r : 2'd0;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_pready = 1'b1;
  assign cfg_wr    = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_cal_r;
  assign out_tdata  = ODW'({out_filt_r, out_cms_r});

  assign e_nxt = (EW'(p_r) <<< 16) - EW'(zero_r);
  assign d_abs = e_r[EW-1] ? EW'(-e_r) : EW'(e_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ZMUL: begin
        mul_a = AW'(e_r);
        mul_b = ZERO_GAIN_Q16;
      end
      S_QMUL: begin
        mul_a = $signed(AW'(d_abs));
        mul_b = TWO_OVER_RHO_Q16;
      end
      S_TMUL: begin
        mul_a = $signed(AW'(res_r[SW-1:0]));
        mul_b = $signed(18'(scale_r));
      end
      S_FMUL: begin
        mul_a = AW'(diff_r);
        mul_b = $signed(18'(gain_r));
      end
      S_CMUL: begin
        mul_a = $signed(AW'(smooth_r));
        mul_b = CMS_PER_MS;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign sq_bit   = (QW+1)'(1) << {cnt_r, 1'b0};
  assign sq_trial = res_r + sq_bit;
  assign sq_take  = {1'b0, rem_r} >= sq_trial;

  assign t_raw = prod_r[6 +: TW];
  assign t_ext = 64'(t_raw);
  assign t_sat = (t_ext > SPEED_MAX) ? SPEED_MAX[39:0] : t_ext[39:0];

  assign zsum      = EW'(zero_r) + $signed(prod_r[16 +: EW]);
  assign elapsed   = now_r - hold_r;
  assign err_small = (e_r < EW'(CAL_TOL_Q16)) && (e_r > -EW'(CAL_TOL_Q16));
  assign ssum      = {1'b0, smooth_r} + prod_r[16 +: 41];
  assign c_raw     = prod_r[16 +: 31];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        state_nxt = in_tuser ? S_DONE : S_MED;
      end
      S_MED:  state_nxt = S_ERR;
      S_ERR:  state_nxt = cal_r ? S_QMUL : S_ZMUL;
      S_ZMUL: state_nxt = S_ZUPD;
      S_ZUPD: state_nxt = S_DONE;
      S_QMUL: state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == '0) begin
        state_nxt = S_TMUL;
      end
      S_TMUL: state_nxt = S_TSAT;
      S_TSAT: state_nxt = S_FMUL;
      S_FMUL: state_nxt = S_FUPD;
      S_FUPD: state_nxt = S_CMUL;
      S_CMUL: state_nxt = S_CSAT;
      S_CSAT: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_tready) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MEDIAN_EN: cfg_prdata = 32'(men_r);
      REG_LPF_GAIN:  cfg_prdata = 32'(gain_r);
      REG_SCALE:     cfg_prdata = 32'(scale_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      men_r       <= MEDIAN_EN_RST;
      gain_r      <= LPF_GAIN_RST;
      scale_r     <= SCALE_RST;
      for (int i = 0; i < MEDIAN_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      idx_r       <= '0;
      full_r      <= 1'b0;
      zero_r      <= '0;
      hold_r      <= '0;
      cal_r       <= 1'b0;
      smooth_r    <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_MEDIAN_EN: men_r   <= cfg_pwdata[0];
          REG_LPF_GAIN:  gain_r  <= cfg_pwdata[15:0];
          REG_SCALE:     scale_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end

      if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          now_r <= nin;
          if (in_tuser) begin
            hold_r <= nin;
            cal_r  <= 1'b0;
            p_r    <= '0;
            cms_r  <= '0;
          end else begin
            p_r <= pin;
            if (men_r) begin
              for (int i = 0; i < MEDIAN_DEPTH; i++) begin
                if (widx == 2'(i)) begin
                  ring_r[i] <= pin;
                end
              end
              if (widx == 2'(MEDIAN_DEPTH - 1)) begin
                idx_r  <= '0;
                full_r <= 1'b1;
              end else begin
                idx_r <= widx + 2'd1;
              end
            end
          end
        end
        S_MED: if (men_r && full_r) begin
          p_r <= med3(ring_r[0], ring_r[1], ring_r[2]);
        end
        S_ERR:  e_r <= e_nxt;
        S_ZMUL: prod_r <= mul_a * mul_b;
        S_ZUPD: begin
          zero_r <= zsum[ZW-1:0];
          cms_r  <= '0;
          if (err_small) begin
            if (elapsed > CAL_HOLD_MS) begin
              cal_r <= 1'b1;
            end
          end else begin
            hold_r <= now_r;
          end
        end
        S_QMUL: begin
          rem_r <= QW'(mul_p >>> 4);
          res_r <= '0;
          cnt_r <= CW'(SW - 1);
        end
        S_SQRT: begin
          if (sq_take) begin
            rem_r <= QW'({1'b0, rem_r} - sq_trial);
            res_r <= (res_r >> 1) + sq_bit;
          end else begin
            res_r <= res_r >> 1;
          end
          cnt_r <= cnt_r - CW'(1);
        end
        S_TMUL: prod_r <= mul_a * mul_b;
        S_TSAT: diff_r <= $signed({1'b0, t_sat}) - $signed({1'b0, smooth_r});
        S_FMUL: prod_r <= mul_a * mul_b;
        S_FUPD: smooth_r <= ssum[39:0];
        S_CMUL: prod_r <= mul_a * mul_b;
        S_CSAT: cms_r <= (c_raw[30:24] != '0) ? CMS_MAX : c_raw[23:0];
        S_DONE: if (!out_valid_r || out_tready) begin
          out_cms_r   <= cms_r;
          out_filt_r  <= p_r;
          out_cal_r   <= cal_r;
        end
        default: ;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_zero_speed_uncal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[23:0] == '0)
    else $error("nonzero airspeed while not calibrated");

  a_smooth_only_fupd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_FUPD |=> $stable(smooth_r))
    else $error("filter state changed outside its update step");

  a_zero_only_zupd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_ZUPD |=> $stable(zero_r))
    else $error("zero offset changed outside its update step");

  a_cal_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cal_r) |-> $past(state_r) == S_ZUPD)
    else $error("calibration finished outside the offset update");

endmodule

FILE: dv/tb_pitot_airspeed_conditioner_top.sv
module tb_pitot_airspeed_conditioner_top;
  import pitac_pkg::*;

  localparam int PB    = 21;
  localparam int IN_W  = ((PB + 39) / 8) * 8;
  localparam int OUT_W = ((PB + 31) / 8) * 8;

  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam longint ZERO_GAIN  = 9830;
  localparam longint TOL_Q16    = 66405;
  localparam logic [31:0] HOLD_MS = 32'd250;
  localparam longint RHO_K      = 106999;
  localparam longint SPEED_CAP  = (longint'(1) << 40) - 1;
  localparam longint CMS_CAP    = 16777215;

  typedef struct packed {
    logic [23:0]        cms;
    logic               cal;
    logic signed [20:0] press;
  } airspeed_res_t;

  typedef struct {
    logic               func;
    logic signed [20:0] press;
    logic [31:0]        now;
    bit                 typed;
    airspeed_res_t      want;
  } stim_row_t;

  typedef struct {
    logic        med;
    logic [15:0] gain;
    logic [15:0] scale;
  } reg_set_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [3:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  pitot_airspeed_conditioner_top #(.PRESSURE_BITS(PB)) dut (.*);

  // predictor copy of registers and state
  logic               cfg_med_en   = MEDIAN_EN_RST;
  logic [15:0]        cfg_lpf_gain = LPF_GAIN_RST;
  logic [15:0]        cfg_scale    = SCALE_RST;
  logic signed [20:0] med_ring [3] = '{21'sd0, 21'sd0, 21'sd0};
  logic [1:0]         med_wr_ptr   = 2'd0;
  logic               med_primed   = 1'b0;
  longint             zero_q16     = 0;
  logic [31:0]        hold_ms      = 32'd0;
  logic               cal_flag     = 1'b0;
  longint             speed_q16    = 0;

  airspeed_res_t pending_readings [$];
  int            fault_count = 0;
  int            items_sent = 0;
  bit            tx_burst = 1'b0;
  bit            rx_burst = 1'b0;
  longint        ground_pa = 0;
  logic [31:0]   clock_ms = 32'd0;

  localparam airspeed_res_t NONE = '0;

  stim_row_t directed_rows [18] = '{
    '{FUNC_SAMPLE,  21'sd0,      32'd300,        1'b1, '{24'd0, 1'b1, 21'sd0}},
    '{FUNC_SAMPLE,  21'h0FFFFF,  32'd310,        1'b0, NONE},
    '{FUNC_SAMPLE,  21'h100000,  32'd320,        1'b0, NONE},
    '{FUNC_SAMPLE,  21'h100000,  32'd330,        1'b0, NONE},
    '{FUNC_SAMPLE,  21'h0FFFFF,  32'd340,        1'b0, NONE},
    '{FUNC_SAMPLE,  21'sd1,      32'hFFFF_FFFF,  1'b0, NONE},
    '{FUNC_RESTART, 21'sd0,      32'd400,        1'b1, '{24'd0, 1'b0, 21'sd0}},
    '{FUNC_RESTART, -21'sd1,     32'd500,        1'b1, '{24'd0, 1'b0, 21'sd0}},
    '{FUNC_SAMPLE,  21'sd5,      32'd600,        1'b0, NONE},
    '{FUNC_RESTART, 21'h0FFFFF,  32'hFFFF_FF00,  1'b1, '{24'd0, 1'b0, 21'sd0}},
    '{FUNC_SAMPLE,  21'sd0,      32'hFFFF_FF10,  1'b0, NONE},
    '{FUNC_SAMPLE,  21'sd0,      32'hFFFF_FF40,  1'b0, NONE},
    '{FUNC_SAMPLE,  21'sd0,      32'hFFFF_FF80,  1'b0, NONE},
    '{FUNC_SAMPLE,  21'sd0,      32'h0000_0010,  1'b0, NONE},
    '{FUNC_SAMPLE,  -21'sd1,     32'h0000_0020,  1'b0, NONE},
    '{FUNC_SAMPLE,  21'sd100,    32'h0000_0030,  1'b0, NONE},
    '{FUNC_SAMPLE,  21'sd1000,   32'h0000_0040,  1'b0, NONE},
    '{FUNC_SAMPLE,  -21'sd100000, 32'h0000_0050, 1'b0, NONE}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned rest;
    longint unsigned trial;
    root = 0;
    rest = 0;
    for (int i = 31; i >= 0; i--) begin
      rest  = (rest << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      root  = root << 1;
      if (rest >= trial) begin
        rest = rest - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  function automatic longint median3(input longint a, input longint b, input longint c);
    longint lo;
    longint hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  function automatic airspeed_res_t airspeed_predict(input logic func,
                                                     input logic signed [20:0] press,
                                                     input logic [31:0] now);
    airspeed_res_t r;
    longint p, err, mag, q, t, cms;
    logic [31:0] elapsed;
    r = '0;
    if (func == FUNC_RESTART) begin
      hold_ms  = now;
      cal_flag = 1'b0;
      return r;
    end
    p = press;
    if (cfg_med_en) begin
      med_ring[med_wr_ptr] = press;
      if (med_wr_ptr == 2'd2) begin
        med_wr_ptr = 2'd0;
        med_primed = 1'b1;
      end else begin
        med_wr_ptr = med_wr_ptr + 2'd1;
      end
      if (med_primed) p = median3(med_ring[0], med_ring[1], med_ring[2]);
    end
    err = p * 65536 - zero_q16;
    cms = 0;
    if (cal_flag) begin
      mag = (err < 0) ? -err : err;
      q   = (mag * RHO_K) >>> 4;
      t   = (longint'(int_sqrt(q)) * longint'(cfg_scale)) >>> 6;
      if (t > SPEED_CAP) t = SPEED_CAP;
      speed_q16 = speed_q16 + (((t - speed_q16) * longint'(cfg_lpf_gain)) >>> 16);
      cms = (speed_q16 * 100) >>> 16;
      if (cms > CMS_CAP) cms = CMS_CAP;
    end else begin
      zero_q16 = zero_q16 + ((err * ZERO_GAIN) >>> 16);
      if (err < TOL_Q16 && err > -TOL_Q16) begin
        elapsed = now - hold_ms;
        if (elapsed > HOLD_MS) cal_flag = 1'b1;
      end else begin
        hold_ms = now;
      end
    end
    r.cms   = cms[23:0];
    r.cal   = cal_flag;
    r.press = p[20:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint want_v, input longint got_v);
    fault_count++;
    $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  // result checker
  always @(posedge clk) begin
    airspeed_res_t want;
    logic signed [20:0] got_press;
    if (rst_n && out_tvalid && out_tready) begin
      got_press = out_tdata[PB+23:24];
      if (pending_readings.size() == 0) begin
        fault_count++;
        $display("%0t unexpected item: cms %0d cal %0d press %0d",
                 $time, out_tdata[23:0], out_tuser, got_press);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[23:0] !== want.cms)
          flag_mismatch("airspeed_cms", longint'(want.cms), longint'(out_tdata[23:0]));
        if (out_tuser !== want.cal)
          flag_mismatch("calibrated", longint'(want.cal), longint'(out_tuser));
        if (got_press !== want.press)
          flag_mismatch("filtered_pressure_pa", longint'(want.press), longint'(got_press));
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(input logic func, input logic signed [20:0] press,
                           input logic [31:0] now, input bit typed = 1'b0,
                           input airspeed_res_t want = '0);
    int gap;
    airspeed_res_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {3'b000, now, press};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = airspeed_predict(func, press, now);
    pending_readings.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_MEDIAN_EN: cfg_med_en   = val[0];
      REG_LPF_GAIN:  cfg_lpf_gain = val[15:0];
      REG_SCALE:     cfg_scale    = val[15:0];
      default: ;
    endcase
  endtask

  task automatic reg_check(input logic [1:0] idx, input logic [31:0] want_v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want_v)
      flag_mismatch($sformatf("prdata reg %0d", idx), longint'(want_v), longint'(cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_regs();
    reg_check(REG_MEDIAN_EN, {31'd0, cfg_med_en});
    reg_check(REG_LPF_GAIN, {16'd0, cfg_lpf_gain});
    reg_check(REG_SCALE, {16'd0, cfg_scale});
  endtask

  // restart + settle at ground, then flight, or raw noise
  task automatic run_random(input int count);
    int goal, seg, len, width;
    longint lp, mag;
    logic [31:0] rnd;
    goal = items_sent + count;
    clock_ms = $urandom();
    while (items_sent < goal) begin
      seg = $urandom_range(0, 9);
      tx_burst = ($urandom_range(0, 3) == 0);
      if (seg < 6) begin
        rnd = $urandom();
        send_item(FUNC_RESTART, rnd[20:0], clock_ms);
        len = $urandom_range(40, 80);
        if (len > goal - items_sent) len = goal - items_sent;
        repeat (len) begin
          clock_ms = clock_ms + $urandom_range(3, 20);
          lp = ground_pa;
          if ($urandom_range(0, 3) == 0) lp = lp + longint'($urandom_range(0, 2)) - 1;
          send_item(FUNC_SAMPLE, lp[20:0], clock_ms);
        end
      end
      if (seg < 8) begin
        len = $urandom_range(10, 50);
        if (len > goal - items_sent) len = goal - items_sent;
        repeat (len) begin
          clock_ms = clock_ms + $urandom_range(1, 30);
          width = $urandom_range(0, 21);
          mag = longint'($urandom()) & ((longint'(1) << width) - 1);
          lp = ($urandom_range(0, 1) == 1) ? ground_pa + mag : ground_pa - mag;
          send_item(FUNC_SAMPLE, lp[20:0], clock_ms);
        end
      end else begin
        len = $urandom_range(5, 20);
        if (len > goal - items_sent) len = goal - items_sent;
        repeat (len) begin
          rnd = $urandom();
          send_item(($urandom_range(0, 3) == 0) ? FUNC_RESTART : FUNC_SAMPLE,
                    rnd[20:0], $urandom());
        end
      end
      if ($urandom_range(0, 15) == 0) drain();
      if ($urandom_range(0, 19) == 0)
        ground_pa = longint'($urandom_range(0, 6000)) - 3000;
    end
    drain();
  endtask

  initial begin
    reg_set_t phases [6];
    phases[0] = '{1'b0, 16'hFFFF, 16'hFFFF};
    phases[1] = '{1'b1, 16'h0000, 16'h0000};
    phases[2] = '{1'b1, 16'hFFFF, 16'h0001};
    phases[3] = '{1'b0, 16'h0001, 16'hFFFF};
    phases[4] = '{1'b1, 16'($urandom()), 16'($urandom_range(1, 4096))};
    phases[5] = '{1'b0, 16'($urandom()), 16'($urandom())};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_regs();

    foreach (directed_rows[i])
      send_item(directed_rows[i].func, directed_rows[i].press, directed_rows[i].now,
                directed_rows[i].typed, directed_rows[i].want);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_MEDIAN_EN, {$urandom_range(0, 1) == 0 ? 31'h7FFF_FFFF : 31'd0,
                                phases[ph].med});
      reg_write(REG_LPF_GAIN, {16'($urandom()), phases[ph].gain});
      reg_write(REG_SCALE, {16'($urandom()), phases[ph].scale});
      if (ph == 1) reg_write(REG_UNUSED, $urandom());
      check_regs();
      run_random(190);
    end

    drain();
    repeat (64) @(posedge clk);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
